// ----- design/des_pkg.sv -----
// DES package: permutation tables, S-boxes, key rotation amounts and the
// combinational helpers (IP, FP, E, P, PC-1, PC-2, round function).
// No dependencies; used by des_round, des_block_encrypt_core and the checker.
`default_nettype none

package des_pkg;

    localparam int DES_ROUNDS  = 16;
    localparam int DES_CNT_W   = $clog2(DES_ROUNDS + 1);

    localparam logic [6:0] DES_IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] DES_FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] DES_E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] DES_P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] DES_PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] DES_PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Cumulative left rotation of C and D before each round's PC-2
    localparam logic [4:0] DES_ROT_SUM [DES_ROUNDS] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [3:0] DES_SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    // Table entries count from 1 at the MSB of the source word
    function automatic logic [63:0] des_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = v[64 - DES_IP_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [63:0] des_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = v[64 - DES_FP_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [47:0] des_e(input logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++)
        begin
            r[47 - i] = v[32 - DES_E_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [31:0] des_p(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[31 - i] = v[32 - DES_P_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [55:0] des_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++)
        begin
            r[55 - i] = v[64 - DES_PC1_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [47:0] des_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++)
        begin
            r[47 - i] = v[56 - DES_PC2_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [27:0] des_rotl28(input logic [27:0] h, input logic [4:0] amt);
        logic [55:0] t;
        t = {h, h} << amt;
        return t[55:28];
    endfunction

    // Feistel function: expand, mix subkey, S-boxes, P
    function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] s;
        x = des_e(r) ^ k;
        for (int i = 0; i < 8; i++)
        begin
            six = x[47 - 6 * i -: 6];
            s[31 - 4 * i -: 4] = DES_SBOX[i][{six[5], six[0], six[4:1]}];
        end
        return des_p(s);
    endfunction

endpackage

`default_nettype wire

// ----- design/des_key_if.sv -----
// Key write channel: valid/ready plus the 64-bit key.
// No dependencies.
`default_nettype none

interface des_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_key;

    modport source (output valid, output cipher_key, input ready);
    modport sink   (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

// ----- design/des_pt_if.sv -----
// Plaintext channel: valid/ready plus one 64-bit block.
// No dependencies.
`default_nettype none

interface des_pt_if;
    logic        valid;
    logic        ready;
    logic [63:0] plaintext_block;

    modport source (output valid, output plaintext_block, input ready);
    modport sink   (input valid, input plaintext_block, output ready);
endinterface

`default_nettype wire

// ----- design/des_ct_if.sv -----
// Ciphertext channel: valid/ready plus one 64-bit block.
// No dependencies.
`default_nettype none

interface des_ct_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_block;

    modport source (output valid, output ciphertext_block, input ready);
    modport sink   (input valid, input ciphertext_block, output ready);
endinterface

`default_nettype wire

// ----- design/des_block_encrypt_core.sv -----
// DES encryption core: key register, subkey wiring and sixteen round stages.
// Depends on des_pkg, des_key_if, des_pt_if, des_ct_if and des_round.
//
//   channel   | dir | payload                 | transfer when
//   ----------+-----+-------------------------+-------------------------
//   key_cfg   | in  | cipher_key [63:0]       | key_cfg.valid & ready
//   ptext     | in  | plaintext_block [63:0]  | ptext.valid & ready
//   ctext     | out | ciphertext_block [63:0] | ctext.valid & ready
//
// One block enters per cycle while ptext.ready is high; there is one register
// stage per Feistel round, the last stage's register being the output register.
// IP, final swap and inverse IP are wiring around the first and last rounds.
// Each stage carries its own valid bit, so bubbles close up under a stall on
// ctext; ptext.ready drops only when all sixteen stages are full and ctext
// is stalled.
// Reset clears the valid bits and the key (to zero); key_cfg is always ready.
`default_nettype none

module des_block_encrypt_core
    import des_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    des_key_if.sink   key_cfg,
    des_pt_if.sink    ptext,
    des_ct_if.source  ctext
);

    logic [63:0]     key_reg;
    logic [55:0]     cd;
    logic [47:0]     subkey [DES_ROUNDS];
    logic [DES_ROUNDS:0] vld;
    logic [DES_ROUNDS:0] rdy;
    logic [31:0]     l_s [DES_ROUNDS + 1];
    logic [31:0]     r_s [DES_ROUNDS + 1];

    assign key_cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_cfg.valid)
        begin
            key_reg <= key_cfg.cipher_key;
        end
    end

    // Subkeys are fixed wiring of the key register
    assign cd = des_pc1(key_reg);

    always_comb
    begin
        for (int i = 0; i < DES_ROUNDS; i++)
        begin
            subkey[i] = des_pc2({des_rotl28(cd[55:28], DES_ROT_SUM[i]),
                                 des_rotl28(cd[27:0], DES_ROT_SUM[i])});
        end
    end

    assign vld[0]       = ptext.valid;
    assign ptext.ready  = rdy[0];
    assign {l_s[0], r_s[0]} = des_ip(ptext.plaintext_block);

    for (genvar g = 0; g < DES_ROUNDS; g++)
    begin : g_round
        des_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_l      (l_s[g]),
            .in_r      (r_s[g]),
            .subkey    (subkey[g]),
            .out_valid (vld[g + 1]),
            .out_ready (rdy[g + 1]),
            .out_l     (l_s[g + 1]),
            .out_r     (r_s[g + 1])
        );
    end

    // Swap the halves, then inverse IP
    assign rdy[DES_ROUNDS]        = ctext.ready;
    assign ctext.valid            = vld[DES_ROUNDS];
    assign ctext.ciphertext_block = des_fp({r_s[DES_ROUNDS], l_s[DES_ROUNDS]});

endmodule

`default_nettype wire

// ----- design/des_round.sv -----
// One Feistel round as a pipeline stage with its own valid bit.
// Depends on des_pkg for the round function.
`default_nettype none

module des_round
    import des_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] in_l,
    input  wire logic [31:0] in_r,
    input  wire logic [47:0] subkey,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_l,
    output logic [31:0]      out_r
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] l_reg;
    logic [31:0] r_reg;
    logic [31:0] l_next;
    logic [31:0] r_next;
    logic        load;

    // Take a new item when empty or when the held one moves on
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        l_next     = in_r;
        r_next     = in_l ^ des_f(in_r, subkey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_l     = l_reg;
    assign out_r     = r_reg;

endmodule

`default_nettype wire

// ----- design/des_enc_checker.sv -----
// Port-level checks for des_block_encrypt_core, attached by bind.
// Depends on des_pkg for the pipeline depth.
`default_nettype none

module des_enc_checker
    import des_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pt_valid,
    input wire logic        pt_ready,
    input wire logic        ct_valid,
    input wire logic        ct_ready,
    input wire logic [63:0] ct_data
);

    logic                 pt_xfer;
    logic                 ct_xfer;
    logic [DES_CNT_W-1:0] inflight_reg;
    logic [DES_CNT_W-1:0] inflight_next;

    assign pt_xfer = pt_valid && pt_ready;
    assign ct_xfer = ct_valid && ct_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (pt_xfer && !ct_xfer)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!pt_xfer && ct_xfer)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds
    a_ct_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ct_valid && !ct_ready |=> ct_valid)
        else $error("ciphertext valid dropped while stalled");

    a_ct_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ct_valid && !ct_ready |=> $stable(ct_data))
        else $error("ciphertext changed while stalled");

    // No result without a block inside
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        ct_valid |-> inflight_reg != '0)
        else $error("ciphertext shown with no block in flight");

    // Sixteen stages full and the output stalled: no further transfer in
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == DES_CNT_W'(DES_ROUNDS) && !ct_xfer |-> !pt_xfer)
        else $error("block taken into a full pipeline");

endmodule

bind des_block_encrypt_core des_enc_checker u_des_enc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (ptext.valid),
    .pt_ready (ptext.ready),
    .ct_valid (ctext.valid),
    .ct_ready (ctext.ready),
    .ct_data  (ctext.ciphertext_block)
);

`default_nettype wire
